/* rtl/gnss_nmea_rtcm_frame_receiver_top_defines.svh */
// Assertion macros shared by the frame receiver RTL
`ifndef GNSS_NMEA_RTCM_FRAME_RECEIVER_TOP_DEFINES_SVH
`define GNSS_NMEA_RTCM_FRAME_RECEIVER_TOP_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define GNR_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// assert that a condition implies a consequence in the next cycle
`define GNR_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

/* rtl/gnr_pkg.sv */
// Package with types, constants and helpers for the frame receiver
`timescale 1ns / 1ps
package gnr_pkg;
   localparam int BufferBytesDefault = 2048;
   localparam int CntW = 13;
   localparam int QueueDepth = 4;
   localparam logic [7:0] RtcmPreamble = 8'hD3;
   localparam logic [7:0] NmeaStart = 8'h24;
   localparam logic [7:0] StarChar = 8'h2A;
   localparam logic [7:0] CrChar = 8'h0D;
   localparam logic [7:0] LfChar = 8'h0A;
   localparam logic [24:0] CrcPoly = 25'h1864CFB;
   localparam logic [2:0] ClsOther = 3'd0;
   localparam logic [2:0] ClsPqtmSvin = 3'd3;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_NMEA = 3'b010,
      MODE_RTCM = 3'b100
   } mode_type;

   // frame summary passed from front to back
   typedef struct packed {
      logic        kind;
      logic        star_ok;
      logic [7:0]  xor_sum;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic        crc_match;
      logic        len_match;
      logic [11:0] length;
      logic        ovf;
      logic [2:0]  cls;
      logic [11:0] mtype;
   } frame_type;

   function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
      logic [24:0] c;
      c = {1'b0, crc ^ {b, 16'h0}};
      for (int k = 0; k < 8; k++) begin
         c = {c[23:0], 1'b0};
         if (c[24]) c = c ^ CrcPoly;
      end
      return c[23:0];
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         r = {1'b0, c[3:0] + 4'd9};
      return r;
   endfunction

   function automatic logic [7:0] parse_hex2(input logic [7:0] c1, input logic [7:0] c2);
      logic [4:0] v1;
      logic [4:0] v2;
      logic [7:0] r;
      v1 = hex_val(c1);
      v2 = hex_val(c2);
      r = 8'h0;
      if (c1 == 8'h20 || (c1 >= 8'd9 && c1 <= 8'd13)) begin
         if (!v2[4]) r = {4'h0, v2[3:0]};
      end else if (c1 == 8'h2B || c1 == 8'h2D) begin
         if (!v2[4]) r = (c1 == 8'h2D) ? 8'(9'd256 - {5'h0, v2[3:0]}) : {4'h0, v2[3:0]};
      end else if (!v1[4]) begin
         r = v2[4] ? {4'h0, v1[3:0]} : {v1[3:0], v2[3:0]};
      end
      return r;
   endfunction

   function automatic logic [7:0] pfx_char(input int k, input logic [3:0] i);
      logic [119:0] t;
      case (k)
         0: t = {"$GNGGA", 72'h0};
         1: t = {"$GNRMC", 72'h0};
         2: t = "$PQTMSVINSTATUS";
         3: t = {"$PQTM", 80'h0};
         default: t = {"$PAIR", 80'h0};
      endcase
      return t[8'(119 - 8 * int'(i)) -: 8];
   endfunction

   function automatic logic [3:0] pfx_len(input int k);
      logic [3:0] r;
      case (k)
         0, 1: r = 4'd6;
         2: r = 4'd15;
         default: r = 4'd5;
      endcase
      return r;
   endfunction
endpackage

/* rtl/gnss_nmea_rtcm_frame_receiver_top.sv */
// Top level of the NMEA / RTCM3 frame receiver
// Usage:
//  req_valid/req_stall carry one received byte (req_rx_byte) per request.
//  rsp_valid/rsp_stall carry one frame summary per ended frame: kind, valid,
//  length, overflow, NMEA sentence class, RTCM message type, forward flag.
//  csr_ APB port: register 0 at address 0 is base_forward_enable.
// Throughput: one byte per cycle while req_stall is low; checksums and CRC
//  update as each byte is taken. A frame's result passes the front frame
//  detect, the queue and the back verdict register after its last byte.
// A four-entry queue sits between front and back; req_stall rises only when
//  it is full, so the front keeps taking bytes while a result waits for
//  the receiver.
// When the receiver stalls, the result holds and the queue fills.
// Reset: synchronous, clears the frame state to idle, empties the queue and
//  clears base_forward_enable.
`timescale 1ns / 1ps
module gnss_nmea_rtcm_frame_receiver_top import gnr_pkg::*; #(
   parameter int BUFFER_BYTES = BufferBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_kind,
   output logic        rsp_frame_valid,
   output logic [11:0] rsp_frame_length,
   output logic        rsp_overflow,
   output logic [2:0]  rsp_sentence_class,
   output logic [11:0] rsp_message_type,
   output logic        rsp_forward,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic fwd_en_ff;
   logic push, qfull, qv, qpop;
   frame_type pf, qf;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {31'h0, fwd_en_ff} : 32'h0;
   always_ff @(posedge clock) begin
      if (reset) fwd_en_ff <= 1'b0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         fwd_en_ff <= csr_pwdata[0];
   end

   assign req_stall = qfull;

   gnr_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
      .clock, .reset, .in_valid(req_valid && !req_stall), .in_byte(req_rx_byte),
      .out_push(push), .out_frame(pf));

   gnr_queue u_queue (.clock, .reset, .push, .push_data(pf), .full(qfull),
      .pop_valid(qv), .pop(qpop), .pop_data(qf));

   gnr_back u_back (.clock, .reset, .fwd_en(fwd_en_ff), .in_valid(qv), .in_frame(qf),
      .in_pop(qpop), .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_kind(rsp_frame_kind), .out_ok(rsp_frame_valid), .out_length(rsp_frame_length),
      .out_ovf(rsp_overflow), .out_cls(rsp_sentence_class), .out_mtype(rsp_message_type),
      .out_fwd(rsp_forward));
endmodule

/* rtl/gnr_front.sv */
// Front end: frame detection, running checksums and frame summary
`timescale 1ns / 1ps
module gnr_front import gnr_pkg::*; #(
   parameter int BUFFER_BYTES = BufferBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       out_push,
   output frame_type  out_frame
);
   mode_type    mode_ff, mode_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [23:0] crc_ff, crc_in, rcrc_ff, rcrc_in;
   logic [7:0]  xor_ff, xor_in, prev_ff, prev_in, c1_ff, c1_in, c2_ff, c2_in;
   logic        star_ff, star_in;
   logic [1:0]  dig_ff, dig_in;
   logic [9:0]  plen_ff, plen_in;
   logic [11:0] type_ff, type_in;
   logic [4:0]  pm_ff, pm_in;
   logic [CntW-1:0] i, nc, plen6;
   logic        natural, full;
   frame_type   fr;

   assign i = cnt_ff;
   assign nc = cnt_ff + 1'b1;
   assign plen6 = CntW'(plen_in) + CntW'(6);

   always_comb begin
      mode_in = mode_ff; cnt_in = cnt_ff; crc_in = crc_ff; rcrc_in = rcrc_ff;
      xor_in = xor_ff; prev_in = prev_ff; c1_in = c1_ff; c2_in = c2_ff;
      star_in = star_ff; dig_in = dig_ff; plen_in = plen_ff; type_in = type_ff;
      pm_in = pm_ff; natural = 1'b0; full = 1'b0; out_push = 1'b0;
      fr = '0;
      if (in_valid) begin
         case (mode_ff)
            MODE_IDLE: begin
               if (in_byte == RtcmPreamble || in_byte == NmeaStart) begin
                  mode_in = (in_byte == RtcmPreamble) ? MODE_RTCM : MODE_NMEA;
                  cnt_in = CntW'(1);
                  crc_in = crc_byte(24'h0, in_byte);
                  rcrc_in = {16'h0, in_byte};
                  prev_in = in_byte; xor_in = '0; star_in = 1'b0; dig_in = '0;
                  c1_in = '0; c2_in = '0; plen_in = '0; type_in = '0; pm_in = '1;
               end
            end
            MODE_NMEA: begin
               cnt_in = nc;
               if (!star_ff) begin
                  if (in_byte == StarChar) star_in = 1'b1;
                  else xor_in = xor_ff ^ in_byte;
               end else if (dig_ff < 2'd2) begin
                  if (dig_ff == 2'd0) c1_in = in_byte;
                  else c2_in = in_byte;
                  dig_in = dig_ff + 2'd1;
               end
               for (int k = 0; k < 5; k++)
                  if (i < CntW'(pfx_len(k)) && in_byte != pfx_char(k, i[3:0]))
                     pm_in[k] = 1'b0;
               natural = (prev_ff == CrChar && in_byte == LfChar);
               prev_in = in_byte;
            end
            MODE_RTCM: begin
               cnt_in = nc;
               if (i == CntW'(1)) plen_in = {in_byte[1:0], 8'h0};
               else if (i == CntW'(2)) plen_in = plen_ff | {2'b0, in_byte};
               else if (i == CntW'(3)) type_in = {in_byte, 4'h0};
               else if (i == CntW'(4)) type_in = type_ff | {8'h0, in_byte[7:4]};
               if (i < CntW'(3) || i < CntW'(plen_ff) + CntW'(3))
                  crc_in = crc_byte(crc_ff, in_byte);
               rcrc_in = {rcrc_ff[15:0], in_byte};
               natural = (nc >= CntW'(6) && nc >= plen6);
               prev_in = in_byte;
            end
            default: mode_in = MODE_IDLE;
         endcase
         full = (mode_ff != MODE_IDLE) && (nc >= CntW'(BUFFER_BYTES));
         if ((mode_ff != MODE_IDLE) && (natural || full)) begin
            out_push = 1'b1;
            fr.kind = (mode_ff == MODE_RTCM);
            fr.star_ok = star_in && (dig_in == 2'd2);
            fr.xor_sum = xor_in;
            fr.c1 = c1_in;
            fr.c2 = c2_in;
            fr.crc_match = (rcrc_in == crc_in);
            fr.len_match = (nc == plen6);
            fr.length = nc[11:0];
            fr.ovf = full && !natural;
            fr.cls = ClsOther;
            for (int k = 4; k >= 0; k--)
               if (pm_in[k] && nc >= CntW'(pfx_len(k))) fr.cls = 3'(k + 1);
            fr.mtype = (mode_ff == MODE_RTCM) ? type_in : 12'h0;
            mode_in = MODE_IDLE;
         end
      end
   end

   assign out_frame = fr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff <= cnt_in;
      end
      crc_ff <= crc_in; rcrc_ff <= rcrc_in; xor_ff <= xor_in; prev_ff <= prev_in;
      c1_ff <= c1_in; c2_ff <= c2_in; star_ff <= star_in; dig_ff <= dig_in;
      plen_ff <= plen_in; type_ff <= type_in; pm_ff <= pm_in;
   end

`include "gnss_nmea_rtcm_frame_receiver_top_defines.svh"
   `GNR_ASSERT_IMP(a_push_open, clock, reset, out_push, mode_ff != MODE_IDLE)
   `GNR_ASSERT_NEXT(a_push_idle, clock, reset, out_push, mode_ff == MODE_IDLE)
   `GNR_ASSERT_IMP(a_cnt_bound, clock, reset, mode_ff != MODE_IDLE,
      cnt_ff < CntW'(BUFFER_BYTES))
endmodule

/* rtl/gnr_queue.sv */
// Short FIFO between the front and back ends
`timescale 1ns / 1ps
module gnr_queue import gnr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   output logic      pop_valid,
   input  logic      pop,
   output frame_type pop_data
);
   localparam int AW = $clog2(QueueDepth);
   frame_type mem_ff [QueueDepth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] n_ff;

   assign full = (n_ff == (AW+1)'(QueueDepth));
   assign pop_valid = (n_ff != '0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; n_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         n_ff <= n_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

`include "gnss_nmea_rtcm_frame_receiver_top_defines.svh"
   `GNR_ASSERT_IMP(a_no_overrun, clock, reset, push, !full || pop)
   `GNR_ASSERT_IMP(a_no_underrun, clock, reset, pop, pop_valid)
   `GNR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, n_ff <= (AW+1)'(QueueDepth))
endmodule

/* rtl/gnr_back.sv */
// Back end: checksum verdict, class and forward flag, output register
`timescale 1ns / 1ps
module gnr_back import gnr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fwd_en,
   input  logic        in_valid,
   input  frame_type   in_frame,
   output logic        in_pop,
   output logic        out_valid,
   input  logic        out_stall,
   output logic        out_kind,
   output logic        out_ok,
   output logic [11:0] out_length,
   output logic        out_ovf,
   output logic [2:0]  out_cls,
   output logic [11:0] out_mtype,
   output logic        out_fwd
);
   logic v_ff;
   logic ok, ok_ff, kind_ff, ovf_ff, fwd_ff;
   logic [11:0] len_ff, mt_ff;
   logic [2:0] cls, cls_ff;

   assign ok = in_frame.kind ? (in_frame.len_match && in_frame.crc_match)
             : (in_frame.star_ok && parse_hex2(in_frame.c1, in_frame.c2) == in_frame.xor_sum);
   assign cls = (!in_frame.kind && ok) ? in_frame.cls : ClsOther;
   assign in_pop = in_valid && (!v_ff || !out_stall);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (!v_ff || !out_stall) v_ff <= in_valid;
      if (in_pop) begin
         kind_ff <= in_frame.kind; ok_ff <= ok; len_ff <= in_frame.length;
         ovf_ff <= in_frame.ovf; cls_ff <= cls; mt_ff <= in_frame.mtype;
         fwd_ff <= fwd_en && ok && (in_frame.kind || cls == ClsPqtmSvin);
      end
   end

   assign out_valid = v_ff; assign out_kind = kind_ff; assign out_ok = ok_ff;
   assign out_length = len_ff; assign out_ovf = ovf_ff; assign out_cls = cls_ff;
   assign out_mtype = mt_ff; assign out_fwd = fwd_ff;

`include "gnss_nmea_rtcm_frame_receiver_top_defines.svh"
   `GNR_ASSERT_NEXT(a_hold, clock, reset, out_valid && out_stall, out_valid && $stable(len_ff))
   `GNR_ASSERT_IMP(a_fwd_ok, clock, reset, out_valid && out_fwd, out_ok)
   `GNR_ASSERT_IMP(a_nmea_type, clock, reset, out_valid && !out_kind, out_mtype == 12'h0)
endmodule
